@@ rtl/core/stbs_pkg.sv @@
// Package for the sorted table search core: sizes, command codes, FSM state type.
`timescale 1ns / 1ps

package stbs_pkg;

    localparam int DEPTH   = 1024;
    localparam int ELEM_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 11;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_CHECK
    } state_t;

endpackage

@@ rtl/core/stbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stbs_ram #(
    parameter int WIDTH = stbs_pkg::ELEM_W,
    parameter int DEPTH = stbs_pkg::DEPTH
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/core/sorted_table_binary_search_core.sv @@
// Top level: sorted table with append, clear and lower-bound binary search.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+--------------------------
//   in      | in  | in_valid / in_ready   | func, value
//   out     | out | out_valid / out_ready | found, position, dropped
//
// Clear and append give no item on out; only a search gives an item on out.
// A search does each halving step as a memory read, then a compare, and ends
// with a read at the lower bound for the equality check.
// The element RAM has a single read port, so read and compare take turns.
// Reset clears count, sticky flag and control; the RAM needs no clearing pass.
// A finished result waits in the output register while clears and appends go on.
`timescale 1ns / 1ps

module sorted_table_binary_search_core #(
    parameter int DEPTH = stbs_pkg::DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [stbs_pkg::FUNC_W-1:0]         func,
    input  logic signed [stbs_pkg::ELEM_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                found,
    output logic [stbs_pkg::POS_W-1:0]          position,
    output logic                                dropped
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WIDE_W = (CNT_W > stbs_pkg::POS_W) ? CNT_W : stbs_pkg::POS_W;

    stbs_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic              overflow_reg, overflow_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic signed [stbs_pkg::ELEM_W-1:0] key_reg, key_next;

    logic                        out_valid_reg, out_valid_next;
    logic                        found_reg, found_next;
    logic [stbs_pkg::POS_W-1:0]  position_reg, position_next;
    logic                        dropped_reg, dropped_next;

    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic                         rd_en;
    logic [ADDR_W-1:0]            rd_addr;
    logic [stbs_pkg::ELEM_W-1:0]  rd_data;

    logic              accept;
    logic              range_open;
    logic [CNT_W-1:0]  mid;
    logic              elem_less;
    logic              hit;
    logic              out_free;
    logic [WIDE_W-1:0] lo_wide;

    stbs_ram #(
        .WIDTH (stbs_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept     = in_valid && in_ready;
    assign range_open = lo_reg < hi_reg;
    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign elem_less  = $signed(rd_data) < key_reg;
    assign hit        = (lo_reg < count_reg) && ($signed(rd_data) == key_reg);
    assign out_free   = !out_valid_reg || out_ready;
    assign lo_wide    = WIDE_W'(lo_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                if (accept && func == stbs_pkg::FUNC_SEARCH)
                begin
                    state_next = stbs_pkg::ST_PROBE;
                end
            end
            stbs_pkg::ST_PROBE:
            begin
                state_next = range_open ? stbs_pkg::ST_CMP : stbs_pkg::ST_CHECK;
            end
            stbs_pkg::ST_CMP:
            begin
                state_next = stbs_pkg::ST_PROBE;
            end
            stbs_pkg::ST_CHECK:
            begin
                if (out_free)
                begin
                    state_next = stbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = stbs_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs: handshake and RAM port control
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = mid[ADDR_W-1:0];
        unique case (state_reg)
            stbs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            stbs_pkg::ST_PROBE:
            begin
                if (range_open)
                begin
                    rd_en   = 1'b1;
                    rd_addr = mid[ADDR_W-1:0];
                end
                else
                begin
                    // final read for the equality check; skipped past the end
                    rd_en   = lo_reg < count_reg;
                    rd_addr = lo_reg[ADDR_W-1:0];
                end
            end
            stbs_pkg::ST_CMP,
            stbs_pkg::ST_CHECK:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        position_next  = position_reg;
        dropped_next   = dropped_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[ADDR_W-1:0];

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            unique case (func)
                stbs_pkg::FUNC_CLEAR:
                begin
                    count_next = '0;
                end
                stbs_pkg::FUNC_APPEND:
                begin
                    if (count_reg < CNT_W'(DEPTH))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                end
                stbs_pkg::FUNC_SEARCH:
                begin
                    lo_next  = '0;
                    hi_next  = count_reg;
                    key_next = value;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end

        if (state_reg == stbs_pkg::ST_PROBE)
        begin
            mid_next = mid;
        end

        if (state_reg == stbs_pkg::ST_CMP)
        begin
            if (elem_less)
            begin
                lo_next = mid_reg + CNT_W'(1);
            end
            else
            begin
                hi_next = mid_reg;
            end
        end

        if (state_reg == stbs_pkg::ST_CHECK && out_free)
        begin
            out_valid_next = 1'b1;
            found_next     = hit;
            position_next  = lo_wide[stbs_pkg::POS_W-1:0];
            dropped_next   = overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stbs_pkg::ST_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mid_reg      <= mid_next;
        key_reg      <= key_next;
        found_reg    <= found_next;
        position_reg <= position_next;
        dropped_reg  <= dropped_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;
    assign dropped   = dropped_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count above table depth");

    a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != stbs_pkg::ST_IDLE) |-> (lo_reg <= hi_reg && hi_reg <= count_reg))
        else $error("search bounds out of order");

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stbs_pkg::ST_CMP) |-> (mid_reg >= lo_reg && mid_reg < hi_reg))
        else $error("probe index outside search range");

    a_sticky_flag: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared without reset");

endmodule

@@ tb/stbs_search_checker.sv @@
// Passive checker: predicts lower-bound search answers and compares them on the out channel.
`timescale 1ns / 1ps

module stbs_search_checker
    import stbs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [FUNC_W-1:0]          func,
    input  logic signed [ELEM_W-1:0]   value,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       found,
    input  logic [POS_W-1:0]           position,
    input  logic                       dropped,
    output int                         fail_count,
    output int                         pending,
    output int                         items_seen,
    output int                         answers_seen,
    output int                         hits_seen
);

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             dropped;
    } answer_t;

    answer_t                  expected_answers[$];
    logic signed [ELEM_W-1:0] elems [DEPTH];
    int                       elem_count;
    logic                     overflow;
    int                       mismatches;
    int                       n_items;
    int                       n_answers;
    int                       n_hits;

    function automatic logic [POS_W-1:0] lower_bound_of(input logic signed [ELEM_W-1:0] key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = elem_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (elems[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo[POS_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_t          want;
        answer_t          ans;
        logic [POS_W-1:0] pos;
        if (!rst_n)
        begin
            expected_answers.delete();
            elem_count = 0;
            overflow   = 1'b0;
            mismatches = 0;
            n_items    = 0;
            n_answers  = 0;
            n_hits     = 0;
            fail_count   <= 0;
            pending      <= 0;
            items_seen   <= 0;
            answers_seen <= 0;
            hits_seen    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_answers++;
                if (found === 1'b1)
                    n_hits++;
                if (expected_answers.size() == 0)
                begin
                    $display("%0t: unexpected result found=%0b position=%0d dropped=%0b",
                             $time, found, position, dropped);
                    mismatches++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (found !== want.found)
                    begin
                        $display("%0t: found mismatch: expected %0b, actual %0b",
                                 $time, want.found, found);
                        mismatches++;
                    end
                    if (position !== want.position)
                    begin
                        $display("%0t: position mismatch: expected %0d, actual %0d",
                                 $time, want.position, position);
                        mismatches++;
                    end
                    if (dropped !== want.dropped)
                    begin
                        $display("%0t: dropped mismatch: expected %0b, actual %0b",
                                 $time, want.dropped, dropped);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                n_items++;
                case (func)
                    FUNC_CLEAR:
                        elem_count = 0;
                    FUNC_APPEND:
                        if (elem_count < DEPTH)
                        begin
                            elems[elem_count] = value;
                            elem_count++;
                        end
                        else
                            overflow = 1'b1;
                    FUNC_SEARCH:
                    begin
                        pos = lower_bound_of(value);
                        ans.position = pos;
                        ans.found    = (pos < elem_count) && (elems[pos] == value);
                        ans.dropped  = overflow;
                        expected_answers.push_back(ans);
                    end
                    default: ;  // unused code: no effect
                endcase
            end
            fail_count   <= mismatches;
            pending      <= expected_answers.size();
            items_seen   <= n_items;
            answers_seen <= n_answers;
            hits_seen    <= n_hits;
        end
    end

endmodule

@@ tb/tb_sorted_table_binary_search_core.sv @@
// Testbench top: drives table loads and searches, stalls the result side, gives the verdict.
`timescale 1ns / 1ps

module tb_sorted_table_binary_search_core;
    import stbs_pkg::*;

    localparam logic [FUNC_W-1:0]        FUNC_UNUSED    = 2'd3;
    localparam logic signed [ELEM_W-1:0] ELEM_MIN       = 32'sh8000_0000;
    localparam logic signed [ELEM_W-1:0] ELEM_MAX       = 32'sh7fff_ffff;
    localparam int                       WATCHDOG_LIMIT = 3000;
    localparam int                       LONG_HOLD      = 300;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [FUNC_W-1:0]          func;
    logic signed [ELEM_W-1:0]   value;
    logic                       out_valid;
    logic                       out_ready;
    logic                       found;
    logic [POS_W-1:0]           position;
    logic                       dropped;

    int                         fail_count;
    int                         pending;
    int                         items_seen;
    int                         answers_seen;
    int                         hits_seen;
    int                         stalled_cycles;
    int                         stim_items;
    logic                       send_quiet;
    logic                       recv_quiet;
    logic signed [ELEM_W-1:0]   loaded[$];

    sorted_table_binary_search_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .position  (position),
        .dropped   (dropped)
    );

    stbs_search_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .position     (position),
        .dropped      (dropped),
        .fail_count   (fail_count),
        .pending      (pending),
        .items_seen   (items_seen),
        .answers_seen (answers_seen),
        .hits_seen    (hits_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin
        wait (stalled_cycles >= WATCHDOG_LIMIT);
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, WATCHDOG_LIMIT, pending);
        $display("FAILURE");
        $finish;
    end

    // Result side: random stall per item, quiet stretches, one long hold-off.
    initial
    begin
        int stall;
        int n_taken;
        out_ready  <= 1'b0;
        recv_quiet = 1'b0;
        n_taken    = 0;
        @(posedge rst_n);
        stall = $urandom_range(0, 18);
        forever
        begin
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            n_taken++;
            if ($urandom_range(0, 15) == 0)
                recv_quiet = !recv_quiet;
            if (n_taken == 15)
                stall = LONG_HOLD;
            else if (recv_quiet)
                stall = 0;
            else
                stall = $urandom_range(0, 18);
        end
    end

    task automatic push_item(input logic [FUNC_W-1:0] f, input logic signed [ELEM_W-1:0] v);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        if (f != FUNC_UNUSED)
            stim_items++;
    endtask

    task automatic append_elem(input logic signed [ELEM_W-1:0] v);
        push_item(FUNC_APPEND, v);
        if (loaded.size() < DEPTH)
            loaded.push_back(v);
    endtask

    task automatic clear_table();
        push_item(FUNC_CLEAR, $urandom);
        loaded.delete();
    endtask

    // Sender pauses until every search answer has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic signed [ELEM_W-1:0] next_key();
        int pick;
        int idx;
        pick = $urandom_range(0, 7);
        idx  = (loaded.size() > 0) ? $urandom_range(0, loaded.size() - 1) : 0;
        if (loaded.size() == 0 && pick <= 4)
            pick = 7;
        case (pick)
            0, 1, 2: return loaded[idx];
            3:       return loaded[idx] + 1;
            4:       return loaded[idx] - 1;
            5:       return ELEM_MIN;
            6:       return ELEM_MAX;
            default: return $urandom;
        endcase
    endfunction

    // Sorted load with random spacing, then a burst of searches.
    task automatic sorted_run(input int n_elems, input int n_keys);
        longint cur;
        int     spacing;
        clear_table();
        spacing = $urandom_range(0, 2);
        cur = ($urandom_range(0, 5) == 0) ? longint'(ELEM_MIN) : longint'($signed($urandom));
        for (int i = 0; i < n_elems; i++)
        begin
            append_elem(cur[ELEM_W-1:0]);
            if ($urandom_range(0, 19) == 0)
                push_item(FUNC_UNUSED, $urandom);
            case (spacing)
                0:       cur += $urandom_range(0, 2);
                1:       cur += $urandom_range(1, 1000);
                default: cur += $urandom_range(0, 1 << 28);
            endcase
            if (cur > longint'(ELEM_MAX))
                cur = longint'(ELEM_MAX);
        end
        for (int k = 0; k < n_keys; k++)
            push_item(FUNC_SEARCH, next_key());
    endtask

    task automatic random_phase(input int target);
        int kind;
        int n;
        while (stim_items < target)
        begin
            send_quiet = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(0, 40);
                sorted_run(n, $urandom_range(1, 8));
            end
            else if (kind < 9)
            begin
                // unsorted content, sometimes piled onto what is already loaded
                if ($urandom_range(0, 1) == 0)
                    clear_table();
                n = $urandom_range(0, 10);
                for (int i = 0; i < n; i++)
                    append_elem($urandom);
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    push_item(FUNC_SEARCH, next_key());
            end
            else
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_item(FUNC_UNUSED, $urandom);
                push_item(FUNC_SEARCH, next_key());
            end
        end
    endtask

    initial
    begin
        longint cur;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        func       <= FUNC_CLEAR;
        value      <= '0;
        send_quiet = 1'b0;
        stim_items = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, unused code, unsorted table
        push_item(FUNC_SEARCH, 32'sd0);
        push_item(FUNC_UNUSED, ELEM_MAX);
        append_elem(ELEM_MIN);
        append_elem(-32'sd1);
        append_elem(32'sd0);
        append_elem(32'sd5);
        append_elem(32'sd5);
        append_elem(32'sd5);
        append_elem(ELEM_MAX);
        push_item(FUNC_SEARCH, ELEM_MIN);
        push_item(FUNC_SEARCH, ELEM_MAX);
        push_item(FUNC_SEARCH, 32'sd5);
        push_item(FUNC_SEARCH, 32'sd4);
        push_item(FUNC_SEARCH, -32'sd2);
        push_item(FUNC_SEARCH, -32'sd1);
        wait_drained();
        clear_table();
        push_item(FUNC_SEARCH, ELEM_MAX);
        append_elem(32'sd7);
        push_item(FUNC_SEARCH, 32'sd8);
        push_item(FUNC_UNUSED, -32'sd1);
        append_elem(32'sd9);
        append_elem(32'sd3);
        push_item(FUNC_SEARCH, 32'sd3);

        random_phase(250);

        // full table, searches at extremes and middle, overflow appends, then its top value
        wait_drained();
        send_quiet = 1'b1;
        clear_table();
        cur = -100000;
        for (int i = 0; i < DEPTH; i++)
        begin
            append_elem(cur[ELEM_W-1:0]);
            cur += $urandom_range(0, 3);
        end
        push_item(FUNC_SEARCH, ELEM_MAX);
        push_item(FUNC_SEARCH, ELEM_MIN);
        push_item(FUNC_SEARCH, loaded[DEPTH / 2]);
        for (int i = 0; i < 3; i++)
            append_elem($urandom);
        push_item(FUNC_SEARCH, loaded[DEPTH - 1]);
        push_item(FUNC_SEARCH, loaded[DEPTH - 1] + 1);
        clear_table();
        push_item(FUNC_SEARCH, $urandom);

        stim_items = 0;
        random_phase(150);

        wait_drained();
        repeat (40) @(posedge clk);
        $display("Covered %0d accepted items and %0d search answers (%0d hits).",
                 items_seen, answers_seen, hits_seen);
        $display("Sorted, unsorted and duplicate loads, a full %0d-entry table and overflow.",
                 DEPTH);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
